@@ hw/rtl/fpa_pkg.sv @@
package fpa_pkg;

  localparam int DataW           = 32;
  localparam int FracBitsDefault = 8;
  // Queue depth must be a power of two so that the pointers wrap by themselves.
  localparam int QueueDepth      = 4;

  localparam logic [3:0] MODE_ADD     = 4'd0;
  localparam logic [3:0] MODE_SUB     = 4'd1;
  localparam logic [3:0] MODE_MUL     = 4'd2;
  localparam logic [3:0] MODE_DIV     = 4'd3;
  localparam logic [3:0] MODE_GT      = 4'd4;
  localparam logic [3:0] MODE_LT      = 4'd5;
  localparam logic [3:0] MODE_GE      = 4'd6;
  localparam logic [3:0] MODE_LE      = 4'd7;
  localparam logic [3:0] MODE_EQ      = 4'd8;
  localparam logic [3:0] MODE_NE      = 4'd9;
  localparam logic [3:0] MODE_MIN     = 4'd10;
  localparam logic [3:0] MODE_MAX     = 4'd11;
  localparam logic [3:0] MODE_INC     = 4'd12;
  localparam logic [3:0] MODE_DEC     = 4'd13;
  localparam logic [3:0] MODE_TOINT   = 4'd14;
  localparam logic [3:0] MODE_FROMINT = 4'd15;

  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_CMP    = 2'd1;
  localparam logic [1:0] KIND_MUL    = 2'd2;
  localparam logic [1:0] KIND_DIV    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       mode;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } op_t;

endpackage

@@ hw/rtl/fpa_front.sv @@
module fpa_front import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [3:0]  s_tuser,
  output logic        op_valid,
  input  logic        op_ready,
  output op_t         op
);

  logic [1:0] kind_next;

  always_comb begin
    unique case (s_tuser) inside
      MODE_MUL: kind_next = KIND_MUL;
      MODE_DIV: kind_next = KIND_DIV;
      MODE_GT, MODE_LT, MODE_GE, MODE_LE, MODE_EQ, MODE_NE: kind_next = KIND_CMP;
      default: kind_next = KIND_SIMPLE;
    endcase
  end

  assign s_tready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (s_tready) begin
      op_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op.kind <= kind_next;
      op.mode <= s_tuser;
      op.a    <= s_tdata[31:0];
      op.b    <= s_tdata[63:32];
    end
  end

endmodule

@@ hw/rtl/fpa_queue.sv @@
module fpa_queue import fpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  op_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = count != CntW'(QueueDepth);
  assign out_valid = count != '0;
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_op;
  end

endmodule

@@ hw/rtl/fpa_back.sv @@
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser
);

  localparam int DivW = DataW + FRAC_BITS;

  typedef struct packed {
    logic [1:0]       kind;
    logic             neg;
    logic             dz;
    logic             flag;
    logic [DataW-1:0] value;
    logic [63:0]      prod;
    logic [DataW-1:0] rem;
    logic [DivW-1:0]  dvd;
    logic [DataW-1:0] dvs;
  } stg_t;

  // Stage 0 executes everything but the divide; stages 1..DivW each make
  // one quotient bit, and stage 1 also takes the product apart.
  stg_t stg [DivW+1];
  logic vld [DivW+1];
  logic en;
  stg_t first;

  function automatic stg_t step(stg_t s, logic is_first);
    stg_t            r;
    logic [DataW:0]  trial;
    logic            ge;
    r     = s;
    trial = {s.rem, s.dvd[DivW-1]};
    ge    = trial >= {1'b0, s.dvs};
    r.rem = ge ? DataW'(trial - {1'b0, s.dvs}) : trial[DataW-1:0];
    r.dvd = {s.dvd[DivW-2:0], 1'b0};
    if (s.kind == KIND_DIV) r.value = {s.value[DataW-2:0], ge};
    if (is_first && s.kind == KIND_MUL) r.value = s.prod[FRAC_BITS+DataW-1:FRAC_BITS];
    return r;
  endfunction

  always_comb begin
    logic signed [DataW-1:0] sa;
    logic signed [DataW-1:0] sb;
    logic [DataW-1:0]        abs_a;
    logic [DataW-1:0]        abs_b;
    sa          = op.a;
    sb          = op.b;
    abs_a       = sa[DataW-1] ? -op.a : op.a;
    abs_b       = sb[DataW-1] ? -op.b : op.b;
    first.kind  = op.kind;
    first.neg   = sa[DataW-1] ^ sb[DataW-1];
    first.dz    = (op.mode == MODE_DIV) && (op.b == '0);
    first.flag  = 1'b0;
    first.value = '0;
    first.prod  = 64'(sa * sb);
    first.rem   = '0;
    first.dvd   = DivW'(abs_a) << FRAC_BITS;
    first.dvs   = abs_b;
    unique case (op.mode)
      MODE_ADD:     first.value = op.a + op.b;
      MODE_SUB:     first.value = op.a - op.b;
      MODE_GT:      first.flag = sa > sb;
      MODE_LT:      first.flag = sa < sb;
      MODE_GE:      first.flag = sa >= sb;
      MODE_LE:      first.flag = sa <= sb;
      MODE_EQ:      first.flag = sa == sb;
      MODE_NE:      first.flag = sa != sb;
      MODE_MIN:     first.value = (sa < sb) ? op.a : op.b;
      MODE_MAX:     first.value = (sa > sb) ? op.a : op.b;
      MODE_INC:     first.value = op.a + 1'b1;
      MODE_DEC:     first.value = op.a - 1'b1;
      MODE_TOINT:   first.value = sa >>> FRAC_BITS;
      MODE_FROMINT: first.value = op.a << FRAC_BITS;
      default:      first.value = '0;
    endcase
  end

  // The whole pipe moves together, only when the output word can move.
  assign en       = !m_tvalid || m_tready;
  assign op_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DivW; i++) vld[i] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= op_valid;
      for (int i = 1; i <= DivW; i++) vld[i] <= vld[i-1];
      m_tvalid <= vld[DivW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= first;
      for (int i = 1; i <= DivW; i++) stg[i] <= step(stg[i-1], i == 1);
      if (stg[DivW].kind == KIND_DIV) begin
        m_tdata <= stg[DivW].dz ? '0 :
                   (stg[DivW].neg ? -stg[DivW].value : stg[DivW].value);
      end else begin
        m_tdata <= stg[DivW].value;
      end
      m_tuser <= {stg[DivW].dz, stg[DivW].flag};
    end
  end

endmodule

@@ hw/rtl/fixed_point_alu.sv @@
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata {operand_b, operand_a}, tuser mode
// m_*      out        m_tvalid/m_tready  tdata value, tuser {div_by_zero, flag}
//
// One word is taken per cycle while the queue has room; the divider forms
// one quotient bit per pipeline stage. Reset (rst, synchronous) empties the
// input register, queue and pipeline. A stalled output freezes the execution
// pipeline; the queue in front keeps taking words until it is full.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // mode [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value [31:0]
  output logic [1:0]  m_tuser    // flag [0], div_by_zero [1]
);

  logic fr_valid;
  logic fr_ready;
  op_t  fr_op;
  logic q_valid;
  logic q_ready;
  op_t  q_op;

  fpa_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .op_valid(fr_valid), .op_ready(fr_ready), .op(fr_op)
  );

  fpa_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(fr_valid), .in_ready(fr_ready), .in_op(fr_op),
    .out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

@@ test/fixed_point_alu_tb.sv @@
module fixed_point_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int FracBits = FracBitsDefault;
  localparam int Latency = FracBits + 35;
  localparam int WatchdogLimit = 4000;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic        div_by_zero;
  } alu_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // operand_a [31:0], operand_b [63:32]
  logic [3:0]  s_tuser;   // mode [3:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // value [31:0]
  logic [1:0]  m_tuser;   // flag [0], div_by_zero [1]

  alu_result_t expected_results[$];
  int          mismatches;
  int          idle_cycles;
  bit          allow_idle;
  bit          timed_out;

  fixed_point_alu #(.FRAC_BITS(FracBits)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic alu_result_t compute_alu(logic [3:0] mode, logic [31:0] ua,
                                              logic [31:0] ub);
    alu_result_t r;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quot;
    a = ua;
    b = ub;
    r = '0;
    case (mode)
      MODE_ADD: r.value = ua + ub;
      MODE_SUB: r.value = ua - ub;
      MODE_MUL: begin
        prod = 64'(a) * 64'(b);
        prod = prod >>> FracBits;
        r.value = prod[31:0];
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          num = 64'(a) <<< FracBits;
          quot = num / 64'(b);
          r.value = quot[31:0];
        end
      end
      MODE_GT: r.flag = a > b;
      MODE_LT: r.flag = a < b;
      MODE_GE: r.flag = a >= b;
      MODE_LE: r.flag = a <= b;
      MODE_EQ: r.flag = a == b;
      MODE_NE: r.flag = a != b;
      MODE_MIN: r.value = (a < b) ? ua : ub;
      MODE_MAX: r.value = (a > b) ? ua : ub;
      MODE_INC: r.value = ua + 32'd1;
      MODE_DEC: r.value = ua - 32'd1;
      MODE_TOINT: r.value = a >>> FracBits;
      default: r.value = ua << FracBits;
    endcase
    return r;
  endfunction

  // Holds the valid across back-to-back words; drops it only for an idle burst.
  task automatic send_word(logic [3:0] mode, logic [31:0] a, logic [31:0] b);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {b, a};
    expected_results.push_back(compute_alu(mode, a, b));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic release_input();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0 && !timed_out) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 2047);
      3: return -$urandom_range(0, 2047);
      4: return $urandom_range(0, 65535) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] edge_vals[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                                  32'h8000_0000, 32'h100};
    allow_idle = 1'b0;
    for (int m = 0; m < 16; m++) begin
      send_word(4'(m), edge_vals[m % 6], edge_vals[(m + 3) % 6]);
    end
    // Divide by zero, the overflowing divide, equal operands, and edge cases of the shifts and the multiply.
    send_word(MODE_DIV, 32'h1234, 32'h0);
    send_word(MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(MODE_MIN, 32'h55, 32'h55);
    send_word(MODE_MAX, 32'hffff_ff00, 32'hffff_ff00);
    send_word(MODE_EQ, 32'h8000_0000, 32'h8000_0000);
    send_word(MODE_TOINT, 32'hffff_ff01, 32'h0);
    send_word(MODE_FROMINT, 32'hffff_ffff, 32'hdead_beef);
    send_word(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
    release_input();
  endtask

  task automatic test_random_ops(int count, bit idle);
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  mode;
    allow_idle = idle;
    for (int i = 0; i < count; i++) begin
      mode = 4'($urandom_range(0, 15));
      a = random_operand();
      b = ($urandom_range(0, 9) == 0) ? a : random_operand();
      if (mode == MODE_DIV && $urandom_range(0, 7) == 0) b = '0;
      send_word(mode, a, b);
    end
    release_input();
  endtask

  task automatic test_pause_until_drained();
    test_random_ops(40, 1'b1);
    drain_results();
    test_random_ops(40, 1'b1);
  endtask

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word: value %h", m_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tdata !== exp_r.value || m_tuser[0] !== exp_r.flag ||
              m_tuser[1] !== exp_r.div_by_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected value %h flag %b dz %b, got value %h flag %b dz %b",
                       exp_r.value, exp_r.flag, exp_r.div_by_zero,
                       m_tdata, m_tuser[0], m_tuser[1]);
          end
        end
      end
      if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
        m_tready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        idle_cycles <= $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // The watchdog counts cycles in which no word is accepted on either channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        timed_out = 1'b1;
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    allow_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_pause_until_drained();
    test_random_ops(1250, 1'b1);
    test_random_ops(300, 1'b0);
    drain_results();
    allow_idle = 1'b0;
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
